// ===== src/jcal_pkg.sv =====
// Shared types and constants for the joystick calibration core.
// Used by jcal_div, jcal_dp, jcal_ctrl and the top level.
`timescale 1ns / 1ps
`default_nettype none
package jcal_pkg;
    localparam int ADC_W   = 12;
    localparam int Q15_W   = 16;             // unsigned Q1.15 up to 1.0
    localparam int DB_W    = 15;
    localparam int CMD_W   = 11;
    localparam int PROG_W  = 7;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 15;
    localparam int DIV_NW  = 31;             // dividend / quotient width
    localparam int DIV_DW  = 16;             // divisor width
    localparam int DIV_CW  = 5;
    localparam int IN_DW   = 32;
    localparam int OUT_DW  = 32;
    localparam logic [Q15_W-1:0] Q15_ONE = 16'h8000;

    localparam logic [1:0] ACT_SAMPLE  = 2'd0;
    localparam logic [1:0] ACT_ADVANCE = 2'd1;
    localparam logic [1:0] ACT_CANCEL  = 2'd2;

    localparam logic [1:0] PH_OFF     = 2'd0;
    localparam logic [1:0] PH_RANGE   = 2'd1;
    localparam logic [1:0] PH_CENTER  = 2'd2;
    localparam logic [1:0] PH_CONFIRM = 2'd3;

    localparam logic [CFG_AW-1:0] REG_MIN_X    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_CENTER_X = 3'd1;
    localparam logic [CFG_AW-1:0] REG_MAX_X    = 3'd2;
    localparam logic [CFG_AW-1:0] REG_MIN_Y    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_CENTER_Y = 3'd4;
    localparam logic [CFG_AW-1:0] REG_MAX_Y    = 3'd5;
    localparam logic [CFG_AW-1:0] REG_INVERT   = 3'd6;
    localparam logic [CFG_AW-1:0] REG_DEADBAND = 3'd7;

    typedef struct packed {
        logic load;
        logic avg_wr;
        logic u_start;
        logic u_wr;
        logic v_start;
        logic v_wr;
        logic mul_wr;
        logic out_load;
        logic ax;
    } jcal_cmd_t;

    typedef struct packed {
        logic avg_pend;
        logic div_done;
        logic u_below_db;
        logic out_free;
    } jcal_sts_t;
endpackage
`default_nettype wire

// ===== src/jcal_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on jcal_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module jcal_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [jcal_pkg::DIV_NW-1:0] dividend,
    input  wire logic [jcal_pkg::DIV_DW-1:0] divisor,
    output logic                             done,
    output logic [jcal_pkg::DIV_NW-1:0]      quotient
);
    import jcal_pkg::*;

    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] rem_reg, dsr_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg, done_reg;
    logic [DIV_DW:0]   trial, diff;
    logic              qbit;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_NW-1]};
        diff  = trial - {1'b0, dsr_reg};
        qbit  = (trial >= {1'b0, dsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CW'(DIV_NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_NW-2:0], qbit};
            rem_reg <= qbit ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

// ===== src/jcal_dp.sv =====
// Datapath: calibration state, configuration registers, axis math, result register.
// Depends on jcal_pkg and jcal_div.
`timescale 1ns / 1ps
`default_nettype none
module jcal_dp #(
    parameter int CENTER_SAMPLES = 64,
    parameter int MIN_SPAN       = 200,
    parameter int CMD_MAX        = 1000
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [jcal_pkg::CFG_AW-1:0] cfg_addr,
    input  wire logic [jcal_pkg::CFG_DW-1:0] cfg_wdata,
    input  wire logic [1:0]                  action,
    input  wire logic [jcal_pkg::ADC_W-1:0]  x_count,
    input  wire logic [jcal_pkg::ADC_W-1:0]  y_count,
    input  wire jcal_pkg::jcal_cmd_t         cmd,
    output jcal_pkg::jcal_sts_t              sts,
    input  wire logic                        m_tready,
    output logic                             m_tvalid,
    output logic [jcal_pkg::OUT_DW-1:0]      m_tdata
);
    import jcal_pkg::*;

    localparam int CNT_W = $clog2(CENTER_SAMPLES + 1);
    localparam int SUM_W = ADC_W + CNT_W;
    localparam int MUL_W = Q15_W + $clog2(CMD_MAX + 1);
    localparam logic [CNT_W-1:0] SAMPLES_N = CNT_W'(CENTER_SAMPLES);
    // average by reciprocal multiply, exact for every sum that fits SUM_W
    localparam int AVG_K  = SUM_W + CNT_W;
    localparam int AVG_MW = SUM_W + 2;
    localparam int AVG_PW = SUM_W + AVG_MW;
    localparam logic [AVG_MW-1:0] AVG_M =
        AVG_MW'(((64'd1 << AVG_K) + 64'(CENTER_SAMPLES) - 64'd1) / 64'(CENTER_SAMPLES));

    logic [ADC_W-1:0] dmin_reg [2];
    logic [ADC_W-1:0] dctr_reg [2];
    logic [ADC_W-1:0] dmax_reg [2];
    logic [1:0]       inv_reg;
    logic [DB_W-1:0]  db_reg;

    logic [1:0]       phase_reg;
    logic [ADC_W-1:0] latest_reg [2];
    logic [ADC_W-1:0] wmin_reg [2];
    logic [ADC_W-1:0] wmax_reg [2];
    logic [ADC_W-1:0] wctr_reg [2];
    logic [ADC_W-1:0] smin_reg [2];
    logic [ADC_W-1:0] smax_reg [2];
    logic [ADC_W-1:0] sctr_reg [2];
    logic             present_reg;
    logic [SUM_W-1:0] sum_reg [2];
    logic [CNT_W-1:0] samples_reg;
    logic             avg_pend_reg;
    logic             neg_reg;
    logic [Q15_W-1:0] u_reg, v_reg;
    logic [CMD_W-1:0] cmdx_reg, cmdy_reg;
    logic             mvalid_reg;
    logic [OUT_DW-1:0] mdata_reg;

    logic [ADC_W-1:0] cnt_in [2];
    logic [CNT_W-1:0] samples_inc;
    logic             cal_good;
    logic [AVG_PW-1:0] avg_prod [2];
    logic [ADC_W-1:0] mn, ce, mx, cl;
    logic signed [ADC_W+1:0] sp, sn, mag_s;
    logic [ADC_W-1:0] span, mag;
    logic             neg_c;
    logic             div_start;
    logic [DIV_NW-1:0] div_nd, div_q;
    logic [DIV_DW-1:0] div_dv;
    logic             div_done;
    logic [Q15_W-1:0] u_diff;
    logic [MUL_W-1:0] prod;
    logic [Q15_W-1:0] mag_cmd;
    logic signed [Q15_W:0] cmd_s;

    assign cnt_in[0]   = x_count;
    assign cnt_in[1]   = y_count;
    assign samples_inc = samples_reg + 1'b1;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
            avg_prod[i] = AVG_PW'(sum_reg[i]) * AVG_PW'(AVG_M);
    end

    // min < center < max with enough span, both axes
    always_comb
    begin
        cal_good = 1'b1;
        for (int i = 0; i < 2; i++)
        begin
            if ({2'b0, wmax_reg[i]} < {2'b0, wmin_reg[i]} + (ADC_W+2)'(MIN_SPAN))
                cal_good = 1'b0;
            if (!(wmin_reg[i] < wctr_reg[i] && wctr_reg[i] < wmax_reg[i]))
                cal_good = 1'b0;
        end
    end

    // axis operand selection, clamp and half-span
    always_comb
    begin
        if (present_reg)
        begin
            mn = smin_reg[cmd.ax];
            ce = sctr_reg[cmd.ax];
            mx = smax_reg[cmd.ax];
        end
        else
        begin
            mn = dmin_reg[cmd.ax];
            ce = dctr_reg[cmd.ax];
            mx = dmax_reg[cmd.ax];
        end
        cl = latest_reg[cmd.ax];
        if (cl < mn)
            cl = mn;
        if (cl > mx)
            cl = mx;
        sp = $signed({2'b0, mx}) - $signed({2'b0, ce});
        sn = $signed({2'b0, ce}) - $signed({2'b0, mn});
        if (sp <= 0)
            sp = (ADC_W+2)'(1);
        if (sn <= 0)
            sn = (ADC_W+2)'(1);
        neg_c = (cl < ce);
        mag_s = neg_c ? $signed({2'b0, ce}) - $signed({2'b0, cl})
                      : $signed({2'b0, cl}) - $signed({2'b0, ce});
        mag   = mag_s[ADC_W-1:0];
        span  = neg_c ? sn[ADC_W-1:0] : sp[ADC_W-1:0];
    end

    assign u_diff = u_reg - {1'b0, db_reg};

    always_comb
    begin
        div_start = 1'b0;
        div_nd    = '0;
        div_dv    = '0;
        if (cmd.u_start)
        begin
            div_start = 1'b1;
            div_nd    = DIV_NW'({mag, 15'b0});
            div_dv    = DIV_DW'(span);
        end
        else if (cmd.v_start && !sts.u_below_db)
        begin
            div_start = 1'b1;
            div_nd    = DIV_NW'({u_diff, 15'b0});
            div_dv    = Q15_ONE - {1'b0, db_reg};
        end
    end

    jcal_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_nd),
        .divisor  (div_dv),
        .done     (div_done),
        .quotient (div_q)
    );

    assign prod    = v_reg * MUL_W'(CMD_MAX);
    assign mag_cmd = Q15_W'(prod >> 15);
    assign cmd_s   = (neg_reg ^ inv_reg[cmd.ax]) ? -$signed({1'b0, mag_cmd})
                                                 : $signed({1'b0, mag_cmd});

    // configuration registers, calibration phase and sample count, and the result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dmin_reg[0]  <= '0;
            dctr_reg[0]  <= ADC_W'(2048);
            dmax_reg[0]  <= ADC_W'(4095);
            dmin_reg[1]  <= '0;
            dctr_reg[1]  <= ADC_W'(2048);
            dmax_reg[1]  <= ADC_W'(4095);
            inv_reg      <= '0;
            db_reg       <= DB_W'(1638);
            phase_reg    <= PH_OFF;
            latest_reg[0] <= ADC_W'(2048);
            latest_reg[1] <= ADC_W'(2048);
            present_reg  <= 1'b0;
            samples_reg  <= '0;
            avg_pend_reg <= 1'b0;
            mvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_MIN_X:    dmin_reg[0] <= cfg_wdata[ADC_W-1:0];
                    REG_CENTER_X: dctr_reg[0] <= cfg_wdata[ADC_W-1:0];
                    REG_MAX_X:    dmax_reg[0] <= cfg_wdata[ADC_W-1:0];
                    REG_MIN_Y:    dmin_reg[1] <= cfg_wdata[ADC_W-1:0];
                    REG_CENTER_Y: dctr_reg[1] <= cfg_wdata[ADC_W-1:0];
                    REG_MAX_Y:    dmax_reg[1] <= cfg_wdata[ADC_W-1:0];
                    REG_INVERT:   inv_reg     <= cfg_wdata[1:0];
                    REG_DEADBAND: db_reg      <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                case (action)
                    ACT_SAMPLE:
                    begin
                        latest_reg[0] <= x_count;
                        latest_reg[1] <= y_count;
                        if (phase_reg == PH_CENTER)
                        begin
                            samples_reg <= samples_inc;
                            if (samples_inc >= SAMPLES_N)
                            begin
                                phase_reg    <= PH_CONFIRM;
                                avg_pend_reg <= 1'b1;
                            end
                        end
                    end
                    ACT_ADVANCE:
                    begin
                        if (phase_reg == PH_OFF)
                            phase_reg <= PH_RANGE;
                        else if (phase_reg == PH_RANGE)
                        begin
                            samples_reg <= '0;
                            phase_reg   <= PH_CENTER;
                        end
                        else if (phase_reg == PH_CONFIRM)
                        begin
                            if (cal_good)
                            begin
                                present_reg <= 1'b1;
                                phase_reg   <= PH_OFF;
                            end
                            else
                                phase_reg <= PH_RANGE;
                        end
                    end
                    ACT_CANCEL:
                        phase_reg <= PH_OFF;
                    default: ;
                endcase
            end
            if (cmd.avg_wr)
                avg_pend_reg <= 1'b0;
            if (cmd.out_load)
                mvalid_reg <= 1'b1;
            else if (m_tready)
                mvalid_reg <= 1'b0;
        end
    end

    // calibration payload and axis math
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (action == ACT_SAMPLE)
            begin
                for (int i = 0; i < 2; i++)
                begin
                    if (phase_reg == PH_RANGE)
                    begin
                        if (cnt_in[i] < wmin_reg[i])
                            wmin_reg[i] <= cnt_in[i];
                        if (cnt_in[i] > wmax_reg[i])
                            wmax_reg[i] <= cnt_in[i];
                    end
                    else if (phase_reg == PH_CENTER)
                        sum_reg[i] <= sum_reg[i] + SUM_W'(cnt_in[i]);
                end
            end
            else if (action == ACT_ADVANCE)
            begin
                for (int i = 0; i < 2; i++)
                begin
                    // open range capture from the last counts seen
                    if (phase_reg == PH_OFF ||
                        (phase_reg == PH_CONFIRM && !cal_good))
                    begin
                        wmin_reg[i] <= latest_reg[i];
                        wmax_reg[i] <= latest_reg[i];
                        wctr_reg[i] <= latest_reg[i];
                    end
                    else if (phase_reg == PH_RANGE)
                        sum_reg[i] <= '0;
                    else if (phase_reg == PH_CONFIRM)
                    begin
                        smin_reg[i] <= wmin_reg[i];
                        smax_reg[i] <= wmax_reg[i];
                        sctr_reg[i] <= wctr_reg[i];
                    end
                end
            end
        end
        if (cmd.avg_wr)
        begin
            for (int i = 0; i < 2; i++)
                wctr_reg[i] <= avg_prod[i][AVG_K +: ADC_W];
        end
        if (cmd.u_start)
            neg_reg <= neg_c;
        if (cmd.u_wr)
            u_reg <= (div_q > DIV_NW'(Q15_ONE)) ? Q15_ONE : div_q[Q15_W-1:0];
        if (cmd.v_start && sts.u_below_db)
            v_reg <= '0;
        if (cmd.v_wr)
            v_reg <= div_q[Q15_W-1:0];
        if (cmd.mul_wr)
        begin
            if (cmd.ax)
                cmdy_reg <= cmd_s[CMD_W-1:0];
            else
                cmdx_reg <= cmd_s[CMD_W-1:0];
        end
        if (cmd.out_load)
            mdata_reg <= {PROG_W'(samples_reg), present_reg, phase_reg, cmdy_reg, cmdx_reg};
    end

    always_comb
    begin
        sts.avg_pend   = avg_pend_reg;
        sts.div_done   = div_done;
        sts.u_below_db = (u_reg < {1'b0, db_reg});
        sts.out_free   = !mvalid_reg || m_tready;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
endmodule
`default_nettype wire

// ===== src/jcal_ctrl.sv =====
// Controller: sequences item load, center averaging, per-axis divides and result.
// Depends on jcal_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jcal_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire jcal_pkg::jcal_sts_t sts,
    output jcal_pkg::jcal_cmd_t      cmd
);
    import jcal_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_AVG_S, S_U_S, S_U_W, S_V_S, S_V_W, S_MUL, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   ax_reg, ax_next;

    always_comb
    begin
        state_next = state_reg;
        ax_next    = ax_reg;
        cmd        = '0;
        cmd.ax     = ax_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    ax_next    = 1'b0;
                    state_next = S_AVG_S;
                end
            end
            S_AVG_S:
            begin
                // store both center averages once capture has completed
                if (sts.avg_pend)
                    cmd.avg_wr = 1'b1;
                ax_next    = 1'b0;
                state_next = S_U_S;
            end
            S_U_S:
            begin
                cmd.u_start = 1'b1;
                state_next  = S_U_W;
            end
            S_U_W:
            begin
                if (sts.div_done)
                begin
                    cmd.u_wr   = 1'b1;
                    state_next = S_V_S;
                end
            end
            S_V_S:
            begin
                // inside the deadband the command is zero, skip the divide
                cmd.v_start = 1'b1;
                state_next  = sts.u_below_db ? S_MUL : S_V_W;
            end
            S_V_W:
            begin
                if (sts.div_done)
                begin
                    cmd.v_wr   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_wr = 1'b1;
                ax_next    = 1'b1;
                state_next = ax_reg ? S_OUT : S_U_S;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ax_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ax_reg    <= ax_next;
        end
    end
endmodule
`default_nettype wire

// ===== src/joystick_calibrate_normalize_core.sv =====
// Top level of the joystick calibration and normalization core.
// Depends on jcal_pkg, jcal_ctrl and jcal_dp.
//
//  channel  direction  contents
//  s_*      in         action, x_count, y_count
//  m_*      out        cmd_x, cmd_y, cal_phase_out, user_cal_active, center_progress
//  cfg_*    in         register index and write data, no read-back
//
// One item at a time. A plain item runs two divides per axis plus control
// states. An axis inside the deadband skips its second divide, so with both
// axes inside it an item runs one divide per axis. The single shared divider
// sets the item time; the center averages are computed by reciprocal multiply.
// Reset is asynchronous; the core is ready for items as soon as it is released.
// A result waits in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module joystick_calibrate_normalize_core #(
    parameter int CENTER_SAMPLES = 64,
    parameter int MIN_SPAN       = 200,
    parameter int CMD_MAX        = 1000
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [jcal_pkg::CFG_AW-1:0] cfg_addr,
    input  wire logic [jcal_pkg::CFG_DW-1:0] cfg_wdata,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // [1:0] action, [13:2] x_count, [25:14] y_count, [31:26] zero
    input  wire logic [jcal_pkg::IN_DW-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [10:0] cmd_x, [21:11] cmd_y, [23:22] cal_phase_out,
    // [24] user_cal_active, [31:25] center_progress
    output logic [jcal_pkg::OUT_DW-1:0]      m_tdata
);
    import jcal_pkg::*;

    jcal_cmd_t cmd;
    jcal_sts_t sts;

    jcal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    jcal_dp #(
        .CENTER_SAMPLES (CENTER_SAMPLES),
        .MIN_SPAN       (MIN_SPAN),
        .CMD_MAX        (CMD_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .action    (s_tdata[1:0]),
        .x_count   (s_tdata[13:2]),
        .y_count   (s_tdata[25:14]),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

`ifndef SYNTHESIS
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result loaded over an unread item");
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while one is in work");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.avg_wr, cmd.u_start, cmd.v_start, cmd.mul_wr,
                  cmd.out_load}))
        else $error("conflicting datapath commands");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for joystick_calibrate_normalize_core.
// Drives items on the s_* stream, predicts each result in a scoreboard class
// and checks every m_* item against it. Depends on jcal_pkg and the core.
`timescale 1ns / 1ps
module tb_top;
    import jcal_pkg::*;

    localparam int CENTER_N = 64;
    localparam int SPAN_MIN = 200;
    localparam int FULL_CMD = 1000;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        logic [PROG_W-1:0] progress;
        logic              user_cal;
        logic [1:0]        phase;
        logic [CMD_W-1:0]  cmd_y;
        logic [CMD_W-1:0]  cmd_x;
    } joy_result_t;

    class joy_scoreboard;
        logic [11:0] dflt_min[2], dflt_ctr[2], dflt_max[2];
        logic [1:0]  inv_mask;
        logic [14:0] db_width;
        logic [1:0]  phase;
        logic [11:0] last_cnt[2];
        logic [11:0] wmin[2], wmax[2], wctr[2], smin[2], smax[2], sctr[2];
        logic        saved;
        logic [17:0] csum[2];
        int          ccount;
        joy_result_t pending[$];
        int          errors;

        function new();
            dflt_min = '{0, 0}; dflt_ctr = '{2048, 2048}; dflt_max = '{4095, 4095};
            inv_mask = 0; db_width = 1638; phase = PH_OFF;
            last_cnt = '{2048, 2048}; saved = 0; ccount = 0; errors = 0;
            foreach (wmin[i])
            begin
                wmin[i] = 0; wmax[i] = 0; wctr[i] = 0;
                smin[i] = 0; smax[i] = 0; sctr[i] = 0; csum[i] = 0;
            end
        endfunction

        function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
            case (idx)
                REG_MIN_X:    dflt_min[0] = val[11:0];
                REG_CENTER_X: dflt_ctr[0] = val[11:0];
                REG_MAX_X:    dflt_max[0] = val[11:0];
                REG_MIN_Y:    dflt_min[1] = val[11:0];
                REG_CENTER_Y: dflt_ctr[1] = val[11:0];
                REG_MAX_Y:    dflt_max[1] = val[11:0];
                REG_INVERT:   inv_mask = val[1:0];
                default:      db_width = val[14:0];
            endcase
        endfunction

        function void start_range();
            for (int i = 0; i < 2; i++)
            begin
                wmin[i] = last_cnt[i]; wmax[i] = last_cnt[i]; wctr[i] = last_cnt[i];
            end
            phase = PH_RANGE;
        endfunction

        function bit range_valid();
            for (int i = 0; i < 2; i++)
            begin
                if (int'(wmax[i]) - int'(wmin[i]) < SPAN_MIN) return 0;
                if (!(wmin[i] < wctr[i] && wctr[i] < wmax[i])) return 0;
            end
            return 1;
        endfunction

        function logic [CMD_W-1:0] axis_command(int cnt, int mn, int ce, int mx, bit inv);
            int unsigned mag, sp, sn, span, u, v, m;
            bit          neg;
            if (cnt < mn) cnt = mn;
            if (cnt > mx) cnt = mx;
            sp = (mx - ce <= 0) ? 1 : mx - ce;
            sn = (ce - mn <= 0) ? 1 : ce - mn;
            neg = cnt < ce;
            mag = neg ? ce - cnt : cnt - ce;
            span = neg ? sn : sp;
            u = (mag * 32768) / span;
            if (u > 32768) u = 32768;
            if (u < db_width) v = 0;
            else v = ((u - db_width) * 32768) / (32768 - db_width);
            m = (v * FULL_CMD) / 32768;
            if (inv) neg = !neg;
            return CMD_W'(neg ? -m : m);
        endfunction

        // Advance the calibration state by one item and queue its result.
        function void note_item(logic [IN_DW-1:0] d);
            logic [1:0]  act;
            joy_result_t r;
            int          mn[2], ce[2], mx[2];
            act = d[1:0];
            if (act == ACT_SAMPLE)
            begin
                last_cnt[0] = d[13:2]; last_cnt[1] = d[25:14];
                if (phase == PH_RANGE)
                begin
                    for (int i = 0; i < 2; i++)
                    begin
                        if (last_cnt[i] < wmin[i]) wmin[i] = last_cnt[i];
                        if (last_cnt[i] > wmax[i]) wmax[i] = last_cnt[i];
                    end
                end
                else if (phase == PH_CENTER)
                begin
                    for (int i = 0; i < 2; i++) csum[i] += last_cnt[i];
                    ccount++;
                    if (ccount >= CENTER_N)
                    begin
                        for (int i = 0; i < 2; i++) wctr[i] = 12'(csum[i] / CENTER_N);
                        phase = PH_CONFIRM;
                    end
                end
            end
            else if (act == ACT_ADVANCE)
            begin
                if (phase == PH_OFF) start_range();
                else if (phase == PH_RANGE)
                begin
                    csum[0] = 0; csum[1] = 0; ccount = 0; phase = PH_CENTER;
                end
                else if (phase == PH_CONFIRM)
                begin
                    if (range_valid())
                    begin
                        smin = wmin; smax = wmax; sctr = wctr;
                        saved = 1; phase = PH_OFF;
                    end
                    else start_range();
                end
            end
            else if (act == ACT_CANCEL) phase = PH_OFF;

            for (int i = 0; i < 2; i++)
            begin
                mn[i] = saved ? smin[i] : dflt_min[i];
                ce[i] = saved ? sctr[i] : dflt_ctr[i];
                mx[i] = saved ? smax[i] : dflt_max[i];
            end
            r.cmd_x = axis_command(last_cnt[0], mn[0], ce[0], mx[0], inv_mask[0]);
            r.cmd_y = axis_command(last_cnt[1], mn[1], ce[1], mx[1], inv_mask[1]);
            r.phase = phase;
            r.user_cal = saved;
            r.progress = ccount[PROG_W-1:0];
            pending.push_back(r);
        endfunction

        function void check_result(logic [OUT_DW-1:0] d);
            joy_result_t got, exp_r;
            got = d[OUT_DW-1:0];
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, d);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.cmd_x !== exp_r.cmd_x)
            begin
                $display("%0t: cmd_x expected %0d actual %0d", $time,
                         $signed(exp_r.cmd_x), $signed(got.cmd_x));
                errors++;
            end
            if (got.cmd_y !== exp_r.cmd_y)
            begin
                $display("%0t: cmd_y expected %0d actual %0d", $time,
                         $signed(exp_r.cmd_y), $signed(got.cmd_y));
                errors++;
            end
            if (got.phase !== exp_r.phase)
            begin
                $display("%0t: phase expected %0d actual %0d", $time, exp_r.phase, got.phase);
                errors++;
            end
            if (got.user_cal !== exp_r.user_cal)
            begin
                $display("%0t: user_cal expected %0d actual %0d", $time,
                         exp_r.user_cal, got.user_cal);
                errors++;
            end
            if (got.progress !== exp_r.progress)
            begin
                $display("%0t: progress expected %0d actual %0d", $time,
                         exp_r.progress, got.progress);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_DW-1:0] cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_DW-1:0]  s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_DW-1:0] m_tdata;

    joy_scoreboard sb;
    bit            calm;       // no idling in the last part
    bit            hold_sink;  // long receiver hold-off
    bit            sink_hold_done;

    joystick_calibrate_normalize_core #(
        .CENTER_SAMPLES(CENTER_N), .MIN_SPAN(SPAN_MIN), .CMD_MAX(FULL_CMD)
    ) u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

    // Receiver: random stalls in bursts, one long hold-off on request.
    initial
    begin
        int gap;
        m_tready = 0;
        sink_hold_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (hold_sink && !sink_hold_done)
            begin
                m_tready <= 0;
                repeat (600) @(posedge clk);
                sink_hold_done = 1;
                m_tready <= 1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 14);
                m_tready <= 0;
                repeat (gap) @(posedge clk);
                m_tready <= 1;
            end
            else m_tready <= 1;
        end
    end

    // Leaves tvalid high after the handshake; a random gap before the next item or an idle drops it.
    task automatic send_item(logic [1:0] act, logic [11:0] xc, logic [11:0] yc);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {6'b0, yc, xc, act};
        do @(posedge clk); while (!s_tready);
        sb.note_item({6'b0, yc, xc, act});
    endtask

    task automatic send_sample(logic [11:0] xc, logic [11:0] yc);
        send_item(ACT_SAMPLE, xc, yc);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
        cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic random_defaults();
        for (int a = 0; a < 2; a++)
        begin
            write_reg(CFG_AW'(REG_MIN_X + 3 * a), CFG_DW'($urandom_range(0, 4095)));
            write_reg(CFG_AW'(REG_CENTER_X + 3 * a), CFG_DW'($urandom_range(0, 4095)));
            write_reg(CFG_AW'(REG_MAX_X + 3 * a), CFG_DW'($urandom_range(0, 4095)));
        end
        write_reg(REG_INVERT, CFG_DW'($urandom_range(0, 3)));
        write_reg(REG_DEADBAND, CFG_DW'($urandom_range(0, 32767)));
    endtask

    // A full calibration pass with random content; sometimes cut short.
    task automatic calibration_run(int n_center);
        int lo, hi;
        send_item(ACT_ADVANCE, 0, 0);
        lo = $urandom_range(0, 1500);
        hi = $urandom_range(2500, 4095);
        repeat ($urandom_range(2, 8))
            send_sample(12'($urandom_range(lo, hi)), 12'($urandom_range(lo, hi)));
        if ($urandom_range(0, 9) == 0)
        begin
            send_item(ACT_CANCEL, 0, 0);
            return;
        end
        send_item(ACT_ADVANCE, 0, 0);
        repeat (n_center)
        begin
            if ($urandom_range(0, 19) == 0) send_item(ACT_ADVANCE, 0, 0);
            send_sample(12'($urandom_range(1800, 2300)), 12'($urandom_range(1800, 2300)));
        end
        send_item(ACT_ADVANCE, 0, 0);
    endtask

    initial
    begin
        int count;
        sb = new();
        calm = 0; hold_sink = 0;
        rst_n = 0; cfg_we = 0; cfg_addr = 0; cfg_wdata = 0;
        s_tvalid = 0; s_tdata = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, every action, the unused code, keys in center capture.
        send_sample(0, 4095);
        send_sample(4095, 0);
        send_sample(2048, 2048);
        send_item(ACT_SPARE, 12'hfff, 12'hfff);
        send_item(ACT_CANCEL, 0, 0);
        send_item(ACT_ADVANCE, 0, 0);
        send_sample(10, 4000);
        send_sample(4090, 50);
        send_item(ACT_ADVANCE, 0, 0);
        send_item(ACT_ADVANCE, 0, 0);
        send_sample(2000, 2100);
        send_item(ACT_CANCEL, 0, 0);
        send_sample(3000, 1000);
        wait_drained();
        write_reg(REG_DEADBAND, 0);
        write_reg(REG_INVERT, 3);
        send_sample(4095, 0);
        send_sample(0, 4095);
        wait_drained();
        write_reg(REG_DEADBAND, 32767);
        write_reg(REG_INVERT, 0);
        send_sample(4095, 0);
        wait_drained();
        // Degenerate defaults: min above max, center at an edge.
        write_reg(REG_MIN_X, 4095); write_reg(REG_CENTER_X, 0); write_reg(REG_MAX_X, 0);
        write_reg(REG_MIN_Y, 2000); write_reg(REG_CENTER_Y, 2000);
        write_reg(REG_MAX_Y, 2000); write_reg(REG_DEADBAND, 0);
        send_sample(100, 3000);
        send_sample(4095, 0);
        wait_drained();

        // Long receiver hold-off while items keep coming.
        hold_sink = 1;
        for (int i = 0; i < 20; i++)
            send_sample(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        s_tvalid <= 0;
        wait (sink_hold_done);
        hold_sink = 0;
        wait_drained();

        count = 0;
        while (count < 650)
        begin
            if (count % 150 == 0)
            begin
                wait_drained();
                random_defaults();
            end
            if (count > 550) calm = 1;
            if ($urandom_range(0, 3) != 0)
            begin
                calibration_run($urandom_range(0, 3) == 0 ? 70 : CENTER_N);
                count += 80;
            end
            else
            begin
                repeat (10)
                    send_item(2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)),
                              12'($urandom_range(0, 4095)));
                count += 10;
            end
            repeat (5)
                send_sample(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
            count += 5;
        end

        wait_drained();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
